/* rtl/pdrp_pkg.sv */
// pdrp_pkg: shared types and constants of the palette DAC register port.
// No dependencies; used by every module of the block except pdrp_ram.
`default_nettype none

package pdrp_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned OFF_W   = 4;
  localparam int unsigned PHASE_W = 2;
  localparam int unsigned ENTRY_W = 3 * BYTE_W;
  localparam int unsigned PAL_DEPTH = 256;

  localparam logic [OFF_W-1:0] REG_WADDR   = 4'h0;
  localparam logic [OFF_W-1:0] REG_DATA    = 4'h4;
  localparam logic [OFF_W-1:0] REG_PIXMASK = 4'h8;
  localparam logic [OFF_W-1:0] REG_RADDR   = 4'hC;

  localparam logic CMD_READ  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  localparam logic [PHASE_W-1:0] PHASE_RED   = 2'd0;
  localparam logic [PHASE_W-1:0] PHASE_GREEN = 2'd1;
  localparam logic [PHASE_W-1:0] PHASE_BLUE  = 2'd2;
  localparam logic [PHASE_W-1:0] PHASE_SPARE = 2'd3;

  typedef logic [BYTE_W-1:0]  byte_t;
  typedef logic [ENTRY_W-1:0] entry_t;

  // controller to datapath
  typedef struct packed {
    logic load;    // capture the transaction
    logic fetch;   // issue the palette read
    logic commit;  // update state, form the result
  } pdrp_cmd_t;

endpackage

`default_nettype wire

/* rtl/pdrp_ram.sv */
// pdrp_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module pdrp_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

/* rtl/pdrp_ctrl.sv */
// pdrp_ctrl: transaction sequencer of the palette DAC register port.
// Depends on pdrp_pkg.
`default_nettype none

module pdrp_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  output logic                   out_valid,
  output pdrp_pkg::pdrp_cmd_t    cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXEC = 2'd1;
  localparam logic [1:0] ST_RESP = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic       valid_r, valid_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) state_nxt = ST_EXEC;
      end
      ST_EXEC: state_nxt = ST_RESP;
      ST_RESP: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
    valid_nxt = (state_r == ST_RESP);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
    end
  end

  assign busy       = (state_r != ST_IDLE);
  assign out_valid  = valid_r;
  assign cmd.load   = (state_r == ST_IDLE) && start;
  assign cmd.fetch  = (state_r == ST_EXEC);
  assign cmd.commit = (state_r == ST_RESP);

endmodule

`default_nettype wire

/* rtl/pdrp_datapath.sv */
// pdrp_datapath: index, colour phase, pending bytes, pixel mask and palette.
// Depends on pdrp_pkg and pdrp_ram.
`default_nettype none

module pdrp_datapath (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire pdrp_pkg::pdrp_cmd_t               cmd,
  input  wire logic                              in_command,
  input  wire logic [pdrp_pkg::OFF_W-1:0]        in_offset,
  input  wire logic [pdrp_pkg::BYTE_W-1:0]       in_write_data,
  output logic      [pdrp_pkg::BYTE_W-1:0]       out_read_data,
  output logic                                   out_palette_written
);

  logic                          command_r;
  logic [pdrp_pkg::OFF_W-1:0]    offset_r;
  pdrp_pkg::byte_t               wdata_r;

  pdrp_pkg::byte_t               index_r, index_nxt;
  logic [pdrp_pkg::PHASE_W-1:0]  phase_r, phase_nxt;
  pdrp_pkg::byte_t               red_r, red_nxt;
  pdrp_pkg::byte_t               green_r, green_nxt;
  pdrp_pkg::byte_t               mask_r, mask_nxt;
  logic [pdrp_pkg::PAL_DEPTH-1:0] written_r, written_nxt;
  logic                          hit_r;

  pdrp_pkg::byte_t               rd_r, rd_nxt;
  logic                          pw_r, pw_nxt;

  pdrp_pkg::entry_t              ram_rdata;
  pdrp_pkg::entry_t              entry;
  pdrp_pkg::entry_t              pal_wdata;
  logic                          pal_we;
  logic                          is_addr;

  pdrp_ram #(
    .WIDTH (pdrp_pkg::ENTRY_W),
    .DEPTH (pdrp_pkg::PAL_DEPTH)
  ) u_palette (
    .clk   (clk),
    .we    (pal_we),
    .waddr (index_r),
    .wdata (pal_wdata),
    .re    (cmd.fetch),
    .raddr (index_r),
    .rdata (ram_rdata)
  );

  // entries never written hold the grey ramp
  assign entry     = hit_r ? ram_rdata : {index_r, index_r, index_r};
  assign pal_wdata = {red_r, green_r, wdata_r};
  assign is_addr   = (offset_r == pdrp_pkg::REG_WADDR) || (offset_r == pdrp_pkg::REG_RADDR);

  always_comb begin
    index_nxt   = index_r;
    phase_nxt   = phase_r;
    red_nxt     = red_r;
    green_nxt   = green_r;
    mask_nxt    = mask_r;
    written_nxt = written_r;
    rd_nxt      = '0;
    pw_nxt      = 1'b0;
    pal_we      = 1'b0;
    if (command_r == pdrp_pkg::CMD_WRITE) begin
      if (is_addr) begin
        index_nxt = wdata_r;
        phase_nxt = pdrp_pkg::PHASE_RED;
      end else if (offset_r == pdrp_pkg::REG_DATA) begin
        case (phase_r)
          pdrp_pkg::PHASE_RED: begin
            red_nxt   = wdata_r;
            phase_nxt = pdrp_pkg::PHASE_GREEN;
          end
          pdrp_pkg::PHASE_GREEN: begin
            green_nxt = wdata_r;
            phase_nxt = pdrp_pkg::PHASE_BLUE;
          end
          default: begin
            pal_we               = cmd.commit;
            written_nxt[index_r] = 1'b1;
            index_nxt            = index_r + 8'd1;
            phase_nxt            = pdrp_pkg::PHASE_RED;
            pw_nxt               = 1'b1;
          end
        endcase
      end else if (offset_r == pdrp_pkg::REG_PIXMASK) begin
        mask_nxt = wdata_r;
      end
    end else begin
      if (offset_r == pdrp_pkg::REG_PIXMASK) begin
        rd_nxt = mask_r;
      end else if (is_addr) begin
        rd_nxt = index_r;
      end else if (offset_r == pdrp_pkg::REG_DATA) begin
        case (phase_r)
          pdrp_pkg::PHASE_RED: begin
            rd_nxt    = entry[23:16];
            phase_nxt = pdrp_pkg::PHASE_GREEN;
          end
          pdrp_pkg::PHASE_GREEN: begin
            rd_nxt    = entry[15:8];
            phase_nxt = pdrp_pkg::PHASE_BLUE;
          end
          pdrp_pkg::PHASE_BLUE: begin
            rd_nxt    = entry[7:0];
            phase_nxt = pdrp_pkg::PHASE_RED;
          end
          default: begin
            rd_nxt    = '0;
            phase_nxt = pdrp_pkg::PHASE_GREEN;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      command_r <= in_command;
      offset_r  <= in_offset;
      wdata_r   <= in_write_data;
    end
    if (cmd.fetch) begin
      hit_r <= written_r[index_r];
    end
    if (cmd.commit) begin
      rd_r <= rd_nxt;
      pw_r <= pw_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      index_r   <= '0;
      phase_r   <= pdrp_pkg::PHASE_RED;
      red_r     <= '0;
      green_r   <= '0;
      mask_r    <= '0;
      written_r <= '0;
    end else if (cmd.commit) begin
      index_r   <= index_nxt;
      phase_r   <= phase_nxt;
      red_r     <= red_nxt;
      green_r   <= green_nxt;
      mask_r    <= mask_nxt;
      written_r <= written_nxt;
    end
  end

  assign out_read_data       = rd_r;
  assign out_palette_written = pw_r;

endmodule

`default_nettype wire

/* rtl/palette_dac_register_port_core.sv */
// palette_dac_register_port_core: top level of the palette DAC register port.
// Depends on pdrp_pkg, pdrp_ctrl, pdrp_datapath (and pdrp_ram below it).
//
//   channel   handshake          payload
//   input     start / busy       in_command, in_offset, in_write_data
//   result    out_valid strobe   out_read_data, out_palette_written
//
// Each transaction steps from acceptance to the result strobe through capture,
// palette RAM read, then state update, as the RAM read data is registered.
// A new transaction is accepted in the cycle the previous result is strobed.
// Reset clears the index, phase, pending bytes, pixel mask and the per-entry
// written flags; unwritten entries read as the grey ramp. No reset sweep.
// Results are strobed for one cycle and cannot be stalled.
`default_nettype none

module palette_dac_register_port_core (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic                         in_command,
  input  wire logic [pdrp_pkg::OFF_W-1:0]   in_offset,
  input  wire logic [pdrp_pkg::BYTE_W-1:0]  in_write_data,
  output logic                              out_valid,
  output logic      [pdrp_pkg::BYTE_W-1:0]  out_read_data,
  output logic                              out_palette_written
);

  pdrp_pkg::pdrp_cmd_t cmd;

  pdrp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  pdrp_datapath u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .in_command          (in_command),
    .in_offset           (in_offset),
    .in_write_data       (in_write_data),
    .out_read_data       (out_read_data),
    .out_palette_written (out_palette_written)
  );

endmodule

`default_nettype wire

/* rtl/pdrp_checker.sv */
// pdrp_checker: port-level assertions for palette_dac_register_port_core.
// Depends on pdrp_pkg; bound to the top level at the end of this file.
`default_nettype none

module pdrp_checker (
  input wire logic                         clk,
  input wire logic                         rst_n,
  input wire logic                         start,
  input wire logic                         busy,
  input wire logic                         out_valid,
  input wire logic [pdrp_pkg::BYTE_W-1:0]  out_read_data,
  input wire logic                         out_palette_written
);

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##3 out_valid)
    else $error("result strobe missing three cycles after transaction");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy low after accepted transaction");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobed while busy");

  a_commit_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_palette_written) |-> (out_read_data == '0))
    else $error("commit result carries read data");

endmodule

bind palette_dac_register_port_core pdrp_checker u_pdrp_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .start               (start),
  .busy                (busy),
  .out_valid           (out_valid),
  .out_read_data       (out_read_data),
  .out_palette_written (out_palette_written)
);

`default_nettype wire
